>>> rtl/assert_macros.svh
// Assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Condition holds at every sampled edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant check failed");

`endif

>>> rtl/thp_pkg.sv
package thp_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_CAL_TEMP     = 3'd0;
   localparam logic [2:0] CSR_CAL_PRESS_LO = 3'd1;
   localparam logic [2:0] CSR_CAL_PRESS_HI = 3'd2;
   localparam logic [2:0] CSR_CAL_P9_HUM_A = 3'd3;
   localparam logic [2:0] CSR_CAL_HUM_B    = 3'd4;

   // compensation constants
   localparam logic signed [63:0] T_OFFSET    = 64'sd128000;
   localparam logic [63:0]        P_SCALE     = 64'd3125;
   localparam logic [20:0]        P_BASE      = 21'd1048576;
   localparam logic signed [31:0] H_OFFSET    = 32'sd76800;
   localparam logic signed [31:0] H_CLAMP_MAX = 32'sd419430400;
   localparam logic signed [31:0] H_ROUND_A   = 32'sd16384;
   localparam logic signed [31:0] H_BIAS_B    = 32'sd2097152;
   localparam logic signed [31:0] H_ROUND_B   = 32'sd8192;
   localparam logic signed [31:0] H_BIAS_C    = 32'sd32768;
   localparam logic signed [63:0] P_HALF_47   = 64'sh0000_8000_0000_0000;
   localparam logic signed [63:0] P_SAT_MIN   = -64'sd549755813888;
   localparam logic signed [63:0] P_SAT_MAX   = 64'sd549755813887;

   // unit latencies
   localparam int MUL_LAT  = 2;
   localparam int DIV_BITS = 64;
   localparam int DIV_LAT  = DIV_BITS + 2;

   // stage positions counted from the fine temperature register
   localparam int IN_LEAD     = 3;
   localparam int P_VV        = 1 + MUL_LAT;
   localparam int P_V2        = P_VV + MUL_LAT;
   localparam int P_MD        = P_V2 + 2 + MUL_LAT;
   localparam int P_Q         = P_MD + DIV_LAT;
   localparam int P_OUT       = P_Q + 2 * MUL_LAT + 2;
   localparam int P_HUM       = 10;
   localparam int RSP_LATENCY = P_OUT + IN_LEAD + 1;

endpackage

>>> rtl/thp_mul64.sv
// 64x64 multiply, low 64 bits of the product, two register stages
module thp_mul64 (
   input  logic        clock,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] p
);

   logic [63:0] ll_ff;
   logic [31:0] lh_ff;
   logic [31:0] hl_ff;
   logic [63:0] p_ff;

   // partial products
   always_ff @(posedge clock) begin
      ll_ff <= a[31:0] * b[31:0];
      lh_ff <= 32'(a[31:0] * b[63:32]);
      hl_ff <= 32'(a[63:32] * b[31:0]);
   end

   // combine
   always_ff @(posedge clock) begin
      p_ff <= ll_ff + {32'(lh_ff + hl_ff), 32'b0};
   end

   assign p = p_ff;

endmodule

>>> rtl/thp_div64.sv
// Signed 64-bit divide, truncating, one quotient bit per stage
module thp_div64 (
   input  logic        clock,
   input  logic [63:0] n,
   input  logic [63:0] d,
   output logic [63:0] q
);

   localparam int NB = thp_pkg::DIV_BITS;

   logic [NB-1:0] rem_ff [0:NB];
   logic [NB-1:0] nq_ff  [0:NB];
   logic [NB-1:0] ad_ff  [0:NB];
   logic          sg_ff  [0:NB];
   logic [NB-1:0] q_ff;

   // magnitudes and result sign
   always_ff @(posedge clock) begin
      rem_ff[0] <= '0;
      nq_ff[0]  <= n[NB-1] ? (~n + 64'd1) : n;
      ad_ff[0]  <= d[NB-1] ? (~d + 64'd1) : d;
      sg_ff[0]  <= n[NB-1] ^ d[NB-1];
   end

   // restoring steps
   for (genvar k = 0; k < NB; k++) begin : g_step
      logic [NB:0] trial;
      logic        ge;
      assign trial = {rem_ff[k], nq_ff[k][NB-1]};
      assign ge    = trial >= {1'b0, ad_ff[k]};
      always_ff @(posedge clock) begin
         rem_ff[k+1] <= ge ? NB'(trial - {1'b0, ad_ff[k]}) : trial[NB-1:0];
         nq_ff[k+1]  <= {nq_ff[k][NB-2:0], ge};
         ad_ff[k+1]  <= ad_ff[k];
         sg_ff[k+1]  <= sg_ff[k];
      end
   end

   // apply sign
   always_ff @(posedge clock) begin
      q_ff <= sg_ff[NB] ? (~nq_ff[NB] + 64'd1) : nq_ff[NB];
   end

   assign q = q_ff;

endmodule

>>> rtl/thp_sensor_compensation.sv
// Temperature, pressure and humidity compensation of one raw sample set per
// clock while busy is low. An item is taken whenever start is high and busy
// is low; busy is high only during reset. Each result appears on the rsp_
// ports, marked by rsp_valid, for one cycle; the receiver cannot hold it off.
// The pressure path is the longest: three two-stage multiplies ahead of a
// 64-stage bit-per-stage divider and two more behind it. Calibration
// registers are written through the csr_ port while no item is in flight;
// the block does not enforce this, the user must. They reset to zero.
module thp_sensor_compensation (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [19:0]        req_raw_temperature,
   input  logic [19:0]        req_raw_pressure,
   input  logic [15:0]        req_raw_humidity,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata,
   output logic               rsp_valid,
   output logic signed [26:0] rsp_temperature_centi,
   output logic signed [31:0] rsp_fine_temperature,
   output logic signed [39:0] rsp_pressure_q24_8,
   output logic               rsp_pressure_valid,
   output logic [16:0]        rsp_humidity_q22_10
);

   localparam int MUL_LAT  = thp_pkg::MUL_LAT;
   localparam int V1P_DLY  = thp_pkg::P_V2 - 2;
   localparam int RP_DLY   = thp_pkg::P_V2 + 1 + thp_pkg::IN_LEAD;
   localparam int RH_DLY   = thp_pkg::IN_LEAD;
   localparam int ZERO_DLY = thp_pkg::P_OUT - 1 - thp_pkg::P_MD;
   localparam int QD_DLY   = 2 * MUL_LAT;
   localparam int HUM_DLY  = thp_pkg::P_OUT - thp_pkg::P_HUM;
   localparam int TC_DLY   = thp_pkg::P_OUT - 1;
   localparam int TF_DLY   = thp_pkg::P_OUT;
   localparam int VLD_LEN  = thp_pkg::RSP_LATENCY;

   // calibration registers
   logic [47:0] cal_temp_ff;
   logic [63:0] cal_plo_ff;
   logic [63:0] cal_phi_ff;
   logic [47:0] cal_pha_ff;
   logic [31:0] cal_hb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_temp_ff <= '0;
         cal_plo_ff  <= '0;
         cal_phi_ff  <= '0;
         cal_pha_ff  <= '0;
         cal_hb_ff   <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            thp_pkg::CSR_CAL_TEMP:     cal_temp_ff <= csr_wdata[47:0];
            thp_pkg::CSR_CAL_PRESS_LO: cal_plo_ff  <= csr_wdata;
            thp_pkg::CSR_CAL_PRESS_HI: cal_phi_ff  <= csr_wdata;
            thp_pkg::CSR_CAL_P9_HUM_A: cal_pha_ff  <= csr_wdata[47:0];
            thp_pkg::CSR_CAL_HUM_B:    cal_hb_ff   <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // coefficient fields
   logic [15:0]        t1, p1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
   logic [7:0]         h1, h3;
   logic signed [11:0] h4, h5;
   logic signed [7:0]  h6;

   assign t1 = cal_temp_ff[15:0];
   assign t2 = cal_temp_ff[31:16];
   assign t3 = cal_temp_ff[47:32];
   assign p1 = cal_plo_ff[15:0];
   assign p2 = cal_plo_ff[31:16];
   assign p3 = cal_plo_ff[47:32];
   assign p4 = cal_plo_ff[63:48];
   assign p5 = cal_phi_ff[15:0];
   assign p6 = cal_phi_ff[31:16];
   assign p7 = cal_phi_ff[47:32];
   assign p8 = cal_phi_ff[63:48];
   assign p9 = cal_pha_ff[15:0];
   assign h1 = cal_pha_ff[23:16];
   assign h2 = cal_pha_ff[39:24];
   assign h3 = cal_pha_ff[47:40];
   assign h4 = cal_hb_ff[11:0];
   assign h5 = cal_hb_ff[23:12];
   assign h6 = cal_hb_ff[31:24];

   // accept and valid chain
   logic               accept;
   logic [VLD_LEN-1:0] vld_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[VLD_LEN-2:0], accept};
      end
   end

   // input capture
   logic [19:0] rt_ff, rp_ff;
   logic [15:0] rh_ff;

   always_ff @(posedge clock) begin
      rt_ff <= req_raw_temperature;
      rp_ff <= req_raw_pressure;
      rh_ff <= req_raw_humidity;
   end

   // temperature stage 1: first products
   logic signed [31:0] sd1, dt, ta_ff, dd_ff;

   assign sd1 = $signed({15'b0, rt_ff[19:3]}) - $signed({15'b0, t1, 1'b0});
   assign dt  = $signed({16'b0, rt_ff[19:4]}) - $signed({16'b0, t1});

   always_ff @(posedge clock) begin
      ta_ff <= sd1 * 32'(t2);
      dd_ff <= dt * dt;
   end

   // temperature stage 2
   logic signed [31:0] ta2_ff, bp_ff;

   always_ff @(posedge clock) begin
      ta2_ff <= ta_ff >>> 11;
      bp_ff  <= (dd_ff >>> 12) * 32'(t3);
   end

   // temperature stage 3: fine temperature
   logic signed [31:0] tf_ff;

   always_ff @(posedge clock) begin
      tf_ff <= ta2_ff + (bp_ff >>> 14);
   end

   // hundredths of a degree
   logic signed [31:0] tcw;
   logic [26:0]        tc_ff;

   assign tcw = tf_ff * 32'sd5 + 32'sd128;

   always_ff @(posedge clock) begin
      tc_ff <= 27'(tcw >>> 8);
   end

   // pressure: offset temperature
   logic signed [63:0] v1_ff;
   logic signed [48:0] v1p5_ff, v1p2_ff;

   always_ff @(posedge clock) begin
      v1_ff <= 64'(tf_ff) - thp_pkg::T_OFFSET;
   end

   always_ff @(posedge clock) begin
      v1p5_ff <= $signed(v1_ff[32:0]) * p5;
      v1p2_ff <= $signed(v1_ff[32:0]) * p2;
   end

   // align the narrow products with the squared terms
   logic [V1P_DLY-1:0][48:0] v1p5_d_ff, v1p2_d_ff;

   always_ff @(posedge clock) begin
      v1p5_d_ff <= {v1p5_d_ff[V1P_DLY-2:0], v1p5_ff};
      v1p2_d_ff <= {v1p2_d_ff[V1P_DLY-2:0], v1p2_ff};
   end

   // squared offset and its coefficient products
   logic [63:0] vv, vvp6, vvp3;

   thp_mul64 u_mul_vv (.clock(clock), .a(v1_ff), .b(v1_ff), .p(vv));
   thp_mul64 u_mul_p6 (.clock(clock), .a(vv), .b(64'(p6)), .p(vvp6));
   thp_mul64 u_mul_p3 (.clock(clock), .a(vv), .b(64'(p3)), .p(vvp3));

   // var2 and var1 sums
   logic signed [63:0] v2_ff, v1b_ff;

   always_ff @(posedge clock) begin
      v2_ff  <= $signed(vvp6) + (64'($signed(v1p5_d_ff[V1P_DLY-1])) <<< 17)
              + (64'(p4) <<< 35);
      v1b_ff <= ($signed(vvp3) >>> 8) + (64'($signed(v1p2_d_ff[V1P_DLY-1])) <<< 12);
   end

   // raw pressure delay
   logic [RP_DLY-1:0][19:0] rp_d_ff;
   logic [20:0]             pdiff;

   always_ff @(posedge clock) begin
      rp_d_ff <= {rp_d_ff[RP_DLY-2:0], rp_ff};
   end

   assign pdiff = thp_pkg::P_BASE - {1'b0, rp_d_ff[RP_DLY-1]};

   // divisor base and numerator base
   logic signed [63:0] x1_ff, nm_ff;

   always_ff @(posedge clock) begin
      x1_ff <= v1b_ff + thp_pkg::P_HALF_47;
      nm_ff <= $signed({12'b0, pdiff, 31'b0}) - v2_ff;
   end

   logic [63:0] md, me;

   thp_mul64 u_mul_p1 (.clock(clock), .a(x1_ff), .b({48'b0, p1}), .p(md));
   thp_mul64 u_mul_sc (.clock(clock), .a(nm_ff), .b(thp_pkg::P_SCALE), .p(me));

   // divide
   logic signed [63:0] dv;
   logic [63:0]        dq_raw;
   logic signed [63:0] dq;

   assign dv = $signed(md) >>> 33;

   thp_div64 u_div (.clock(clock), .n(me), .d(dv), .q(dq_raw));

   assign dq = dq_raw;

   // zero divisor flag rides alongside
   logic [ZERO_DLY-1:0] zero_d_ff;

   always_ff @(posedge clock) begin
      zero_d_ff <= {zero_d_ff[ZERO_DLY-2:0], dv == 64'sd0};
   end

   // post-divide corrections
   logic [QD_DLY-1:0][63:0]  qd_ff;
   logic [MUL_LAT-1:0][63:0] g_d_ff;
   logic signed [63:0]       e_now, e_late;
   logic [63:0]              mf, mg, mh;

   assign e_now  = dq >>> 13;
   assign e_late = $signed(qd_ff[MUL_LAT-1]) >>> 13;

   always_ff @(posedge clock) begin
      qd_ff  <= {qd_ff[QD_DLY-2:0], dq_raw};
      g_d_ff <= {g_d_ff[MUL_LAT-2:0], mg};
   end

   thp_mul64 u_mul_p9 (.clock(clock), .a(64'(p9)), .b(e_now), .p(mf));
   thp_mul64 u_mul_p8 (.clock(clock), .a(64'(p8)), .b(dq), .p(mg));
   thp_mul64 u_mul_ee (.clock(clock), .a(mf), .b(e_late), .p(mh));

   // final sum, offset and saturation
   logic signed [63:0] sum_ff, pf;
   logic [39:0]        pres_ff;
   logic               pv_ff;

   always_ff @(posedge clock) begin
      sum_ff <= $signed(qd_ff[QD_DLY-1]) + ($signed(mh) >>> 25)
              + ($signed(g_d_ff[MUL_LAT-1]) >>> 19);
   end

   assign pf = (sum_ff >>> 8) + (64'(p7) <<< 4);

   always_ff @(posedge clock) begin
      pv_ff <= !zero_d_ff[ZERO_DLY-1];
      priority if (zero_d_ff[ZERO_DLY-1]) begin
         pres_ff <= '0;
      end else if (pf < thp_pkg::P_SAT_MIN) begin
         pres_ff <= thp_pkg::P_SAT_MIN[39:0];
      end else if (pf > thp_pkg::P_SAT_MAX) begin
         pres_ff <= thp_pkg::P_SAT_MAX[39:0];
      end else begin
         pres_ff <= pf[39:0];
      end
   end

   // humidity stage 1
   logic [RH_DLY-1:0][15:0] rh_d_ff;
   logic signed [31:0]      hx_ff, ha0_ff;

   always_ff @(posedge clock) begin
      rh_d_ff <= {rh_d_ff[RH_DLY-2:0], rh_ff};
   end

   always_ff @(posedge clock) begin
      hx_ff  <= tf_ff - thp_pkg::H_OFFSET;
      ha0_ff <= $signed({2'b0, rh_d_ff[RH_DLY-1], 14'b0}) - $signed({h4, 20'b0});
   end

   // humidity stage 2: products with x
   logic signed [31:0] hx5_ff, xh6_ff, xh3_ff, ha2_ff;

   always_ff @(posedge clock) begin
      hx5_ff <= 32'(h5) * hx_ff;
      xh6_ff <= hx_ff * 32'(h6);
      xh3_ff <= hx_ff * $signed({24'b0, h3});
      ha2_ff <= ha0_ff;
   end

   // humidity stage 3
   logic signed [31:0] ha3_ff, hb0_ff, hc_ff;

   always_ff @(posedge clock) begin
      ha3_ff <= (ha2_ff - hx5_ff + thp_pkg::H_ROUND_A) >>> 15;
      hb0_ff <= xh6_ff >>> 10;
      hc_ff  <= (xh3_ff >>> 11) + thp_pkg::H_BIAS_C;
   end

   // humidity stage 4
   logic signed [31:0] hbm_ff, ha4_ff;

   always_ff @(posedge clock) begin
      hbm_ff <= hb0_ff * hc_ff;
      ha4_ff <= ha3_ff;
   end

   // humidity stage 5
   logic signed [31:0] hbh2_ff, ha5_ff;

   always_ff @(posedge clock) begin
      hbh2_ff <= ((hbm_ff >>> 10) + thp_pkg::H_BIAS_B) * 32'(h2);
      ha5_ff  <= ha4_ff;
   end

   // humidity stage 6
   logic signed [31:0] hb6_ff, ha6_ff;

   always_ff @(posedge clock) begin
      hb6_ff <= (hbh2_ff + thp_pkg::H_ROUND_B) >>> 14;
      ha6_ff <= ha5_ff;
   end

   // humidity stage 7
   logic signed [31:0] hv_ff;

   always_ff @(posedge clock) begin
      hv_ff <= ha6_ff * hb6_ff;
   end

   // humidity stage 8
   logic signed [31:0] hw, hww_ff, hv8_ff;

   assign hw = hv_ff >>> 15;

   always_ff @(posedge clock) begin
      hww_ff <= hw * hw;
      hv8_ff <= hv_ff;
   end

   // humidity stage 9
   logic signed [31:0] hwq_ff, hv9_ff;

   always_ff @(posedge clock) begin
      hwq_ff <= (hww_ff >>> 7) * $signed({24'b0, h1});
      hv9_ff <= hv8_ff;
   end

   // humidity stage 10: subtract and clamp
   logic signed [31:0] hr;
   logic [16:0]        hum_ff;

   assign hr = hv9_ff - (hwq_ff >>> 4);

   always_ff @(posedge clock) begin
      priority if (hr < 32'sd0) begin
         hum_ff <= '0;
      end else if (hr > thp_pkg::H_CLAMP_MAX) begin
         hum_ff <= thp_pkg::H_CLAMP_MAX[28:12];
      end else begin
         hum_ff <= hr[28:12];
      end
   end

   // align temperature and humidity with pressure
   logic [TF_DLY-1:0][31:0]  tf_d_ff;
   logic [TC_DLY-1:0][26:0]  tc_d_ff;
   logic [HUM_DLY-1:0][16:0] hum_d_ff;

   always_ff @(posedge clock) begin
      tf_d_ff  <= {tf_d_ff[TF_DLY-2:0], tf_ff};
      tc_d_ff  <= {tc_d_ff[TC_DLY-2:0], tc_ff};
      hum_d_ff <= {hum_d_ff[HUM_DLY-2:0], hum_ff};
   end

   // result ports
   assign rsp_valid             = vld_ff[VLD_LEN-1];
   assign rsp_temperature_centi = tc_d_ff[TC_DLY-1];
   assign rsp_fine_temperature  = tf_d_ff[TF_DLY-1];
   assign rsp_pressure_q24_8    = pres_ff;
   assign rsp_pressure_valid    = pv_ff;
   assign rsp_humidity_q22_10   = hum_d_ff[HUM_DLY-1];

endmodule

>>> rtl/thp_checker.sv
`include "assert_macros.svh"

// Port-level checks on the compensation block
module thp_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [19:0]        req_raw_temperature,
   input logic [19:0]        req_raw_pressure,
   input logic [15:0]        req_raw_humidity,
   input logic               csr_write,
   input logic [2:0]         csr_index,
   input logic [63:0]        csr_wdata,
   input logic               rsp_valid,
   input logic signed [26:0] rsp_temperature_centi,
   input logic signed [31:0] rsp_fine_temperature,
   input logic signed [39:0] rsp_pressure_q24_8,
   input logic               rsp_pressure_valid,
   input logic [16:0]        rsp_humidity_q22_10
);

   // every result traces back to an item taken a fixed time earlier
   `ASSERT_IMPLIES(a_rsp_origin, clock, reset, rsp_valid, $past(start && !busy, thp_pkg::RSP_LATENCY))

   // a zero divisor reports zero pressure
   `ASSERT_IMPLIES(a_press_zero, clock, reset, rsp_valid && !rsp_pressure_valid, rsp_pressure_q24_8 == 40'sd0)

   // clamped humidity never exceeds full scale
   `ASSERT_ALWAYS(a_hum_range, clock, reset, !rsp_valid || rsp_humidity_q22_10 <= 17'd102400)

endmodule

bind thp_sensor_compensation thp_checker u_thp_checker (.*);

>>> tb/thp_sensor_compensation_tb.sv
`timescale 1ns / 100ps

module thp_sensor_compensation_tb;

   localparam logic [2:0] CSR_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [19:0] raw_t;
      logic [19:0] raw_p;
      logic [15:0] raw_h;
   } sample_type;

   typedef struct {
      logic signed [26:0] temp_centi;
      logic signed [31:0] fine_temp;
      logic signed [39:0] press;
      logic               press_ok;
      logic [16:0]        hum;
   } comp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [19:0]        req_raw_temperature = '0;
   logic [19:0]        req_raw_pressure = '0;
   logic [15:0]        req_raw_humidity = '0;
   logic               csr_write = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [63:0]        csr_wdata = '0;
   logic               rsp_valid;
   logic signed [26:0] rsp_temperature_centi;
   logic signed [31:0] rsp_fine_temperature;
   logic signed [39:0] rsp_pressure_q24_8;
   logic               rsp_pressure_valid;
   logic [16:0]        rsp_humidity_q22_10;

   thp_sensor_compensation dut (.*);

   always #5 clock = ~clock;

   // calibration copy, masked to register widths
   logic [63:0] cal_t, cal_pl, cal_ph, cal_ph9, cal_hb;

   sample_type samples_q[$];
   comp_type   comp_q[$];
   sample_type cur;
   int         gap = 0;
   bit         idle_en = 1;
   int         errors = 0;
   int         cycles = 0;

   function automatic longint div_trunc(longint n, longint d);
      logic [63:0] an, ad, q;
      an = (n < 0) ? -n : n;
      ad = (d < 0) ? -d : d;
      q = an / ad;
      return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
   endfunction

   function automatic comp_type compensate(sample_type s);
      comp_type r;
      int t1, t2, t3, rt, ta, tb, td, tf, tc;
      longint p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, e;
      int h1, h2, h3, h4, h5, h6, rh, x, ha, hb, hc, v, hs, q;
      t1 = {16'b0, cal_t[15:0]};
      t2 = 32'($signed(cal_t[31:16]));
      t3 = 32'($signed(cal_t[47:32]));
      p1 = {48'b0, cal_pl[15:0]};
      p2 = 64'($signed(cal_pl[31:16]));
      p3 = 64'($signed(cal_pl[47:32]));
      p4 = 64'($signed(cal_pl[63:48]));
      p5 = 64'($signed(cal_ph[15:0]));
      p6 = 64'($signed(cal_ph[31:16]));
      p7 = 64'($signed(cal_ph[47:32]));
      p8 = 64'($signed(cal_ph[63:48]));
      p9 = 64'($signed(cal_ph9[15:0]));
      h1 = {24'b0, cal_ph9[23:16]};
      h2 = 32'($signed(cal_ph9[39:24]));
      h3 = {24'b0, cal_ph9[47:40]};
      h4 = 32'($signed(cal_hb[11:0]));
      h5 = 32'($signed(cal_hb[23:12]));
      h6 = 32'($signed(cal_hb[31:24]));
      // temperature, 32-bit wrap
      rt = {12'b0, s.raw_t};
      ta = (((rt >> 3) - (t1 << 1)) * t2) >>> 11;
      td = (rt >> 4) - t1;
      tb = (((td * td) >>> 12) * t3) >>> 14;
      tf = ta + tb;
      tc = (tf * 5 + 128) >>> 8;
      // pressure, 64-bit wrap
      v1 = longint'(tf) - thp_pkg::T_OFFSET;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) << 17);
      v2 = v2 + (p4 << 35);
      v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) << 12);
      v1 = ((thp_pkg::P_HALF_47 + v1) * p1) >>> 33;
      r.press = '0;
      r.press_ok = 1'b0;
      if (v1 != 0) begin
         p = longint'(thp_pkg::P_BASE) - longint'({44'b0, s.raw_p});
         p = div_trunc(((p << 31) - v2) * longint'(thp_pkg::P_SCALE), v1);
         e = p >>> 13;
         v1 = (p9 * e * e) >>> 25;
         v2 = (p8 * p) >>> 19;
         p = ((p + v1 + v2) >>> 8) + (p7 << 4);
         if (p < thp_pkg::P_SAT_MIN) p = thp_pkg::P_SAT_MIN;
         else if (p > thp_pkg::P_SAT_MAX) p = thp_pkg::P_SAT_MAX;
         r.press = p[39:0];
         r.press_ok = 1'b1;
      end
      // humidity, 32-bit wrap
      rh = {16'b0, s.raw_h};
      x = tf - thp_pkg::H_OFFSET;
      ha = (rh << 14) - (h4 << 20);
      ha = ha - h5 * x;
      ha = (ha + thp_pkg::H_ROUND_A) >>> 15;
      hb = (x * h6) >>> 10;
      hc = ((x * h3) >>> 11) + thp_pkg::H_BIAS_C;
      hb = hb * hc;
      hb = (hb >>> 10) + thp_pkg::H_BIAS_B;
      hb = (hb * h2 + thp_pkg::H_ROUND_B) >>> 14;
      v = ha * hb;
      hs = v >>> 15;
      q = (((hs * hs) >>> 7) * h1) >>> 4;
      v = v - q;
      if (v < 0) v = 0;
      if (v > thp_pkg::H_CLAMP_MAX) v = thp_pkg::H_CLAMP_MAX;
      r.hum = v[28:12];
      r.temp_centi = tc[26:0];
      r.fine_temp = tf;
      return r;
   endfunction

   task automatic report(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h", field, got, want);
      errors++;
   endtask

   // driver: an item goes out whenever the slot is free and no idle burst runs
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) comp_q.push_back(compensate(cur));
         if (!start || !busy) begin
            if (gap > 0) begin
               gap--;
               start <= 1'b0;
            end else if (samples_q.size() > 0) begin
               cur = samples_q.pop_front();
               req_raw_temperature <= cur.raw_t;
               req_raw_pressure <= cur.raw_p;
               req_raw_humidity <= cur.raw_h;
               start <= 1'b1;
               if (idle_en && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 12);
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: each result against the oldest expectation
   always @(posedge clock) begin
      comp_type w;
      if (!reset && rsp_valid) begin
         if (comp_q.size() == 0) begin
            report("unexpected item", 64'd0, 64'd0);
         end else begin
            w = comp_q.pop_front();
            if (rsp_temperature_centi !== w.temp_centi)
               report("temperature_centi", 64'(rsp_temperature_centi), 64'(w.temp_centi));
            if (rsp_fine_temperature !== w.fine_temp)
               report("fine_temperature", 64'(rsp_fine_temperature), 64'(w.fine_temp));
            if (rsp_pressure_q24_8 !== w.press)
               report("pressure_q24_8", 64'(rsp_pressure_q24_8), 64'(w.press));
            if (rsp_pressure_valid !== w.press_ok)
               report("pressure_valid", 64'(rsp_pressure_valid), 64'(w.press_ok));
            if (rsp_humidity_q22_10 !== w.hum)
               report("humidity_q22_10", 64'(rsp_humidity_q22_10), 64'(w.hum));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic csr_put(logic [2:0] idx, logic [63:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         thp_pkg::CSR_CAL_TEMP:     cal_t = data & 64'hFFFF_FFFF_FFFF;
         thp_pkg::CSR_CAL_PRESS_LO: cal_pl = data;
         thp_pkg::CSR_CAL_PRESS_HI: cal_ph = data;
         thp_pkg::CSR_CAL_P9_HUM_A: cal_ph9 = data & 64'hFFFF_FFFF_FFFF;
         thp_pkg::CSR_CAL_HUM_B:    cal_hb = data & 64'hFFFF_FFFF;
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic load_cal(logic [63:0] ct, logic [63:0] pl, logic [63:0] ph,
                           logic [63:0] p9a, logic [63:0] hb);
      csr_put(thp_pkg::CSR_CAL_TEMP, ct);
      csr_put(thp_pkg::CSR_CAL_PRESS_LO, pl);
      csr_put(thp_pkg::CSR_CAL_PRESS_HI, ph);
      csr_put(thp_pkg::CSR_CAL_P9_HUM_A, p9a);
      csr_put(thp_pkg::CSR_CAL_HUM_B, hb);
   endtask

   task automatic load_typical();
      load_cal(64'({16'hFC18, 16'd26435, 16'd27504}),
               {16'd2855, 16'd3024, 16'hD643, 16'd36477},
               {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
               64'({8'd0, 16'd362, 8'd75, 16'd6000}),
               64'({8'd30, 12'd50, 12'd313}));
   endtask

   task automatic add_sample(logic [19:0] t, logic [19:0] p, logic [15:0] h);
      sample_type s;
      s.raw_t = t;
      s.raw_p = p;
      s.raw_h = h;
      samples_q.push_back(s);
   endtask

   task automatic add_random(int n);
      repeat (n) add_sample(20'($urandom), 20'($urandom), 16'($urandom));
   endtask

   // wait until every item is out and every result has come back
   task automatic drain();
      wait (samples_q.size() == 0 && !start && comp_q.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      cal_t = 0; cal_pl = 0; cal_ph = 0; cal_ph9 = 0; cal_hb = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset calibration: pressure divisor is zero
      add_sample(20'd519888, 20'd415148, 16'd30000);
      add_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      drain();

      // typical calibration, field extremes
      load_typical();
      add_sample(20'd519888, 20'd415148, 16'd30000);
      add_sample(20'd0, 20'd0, 16'd0);
      add_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      add_sample(20'hFFFFF, 20'd0, 16'd0);
      add_sample(20'd0, 20'hFFFFF, 16'hFFFF);
      add_sample(20'd440064, 20'd1048575, 16'd65000);
      add_sample(20'd600000, 20'd300000, 16'd10);
      add_sample(20'd400000, 20'd500000, 16'd45000);
      drain();

      // all-ones calibration, writes with bits above width, unused index
      load_cal('1, '1, '1, '1, '1);
      csr_put(CSR_UNUSED, {$urandom, $urandom});
      add_sample(20'd0, 20'd0, 16'd0);
      add_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      add_sample(20'h55555, 20'hAAAAA, 16'h5A5A);
      add_sample(20'hAAAAA, 20'h55555, 16'hA5A5);
      drain();

      // random phases: alternate random and typical calibration
      for (int ph = 0; ph < 8; ph++) begin
         if (ph % 2 == 0)
            load_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
         else
            load_typical();
         if (ph == 7) idle_en = 0;
         add_random(85);
         drain();
      end

      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/thp_pkg.sv
rtl/thp_mul64.sv
rtl/thp_div64.sv
rtl/thp_sensor_compensation.sv
rtl/thp_checker.sv
tb/thp_sensor_compensation_tb.sv
